[design/apq_pkg.sv]
package apq_pkg;

  // number of entries the queue can hold
  localparam int Capacity = 64;
  // width of the fill count, able to hold Capacity itself
  localparam int CountW = $clog2(Capacity + 1);
  // width of the entry count field on the result
  localparam int OutCountW = 7;

  // result status codes
  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  // operation codes on the request
  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  // one stored entry
  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] value;
  } entry_t;

  // what the chain does in a cycle
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE
  } cmd_t;

  // control broadcast to every cell
  typedef struct packed {
    cmd_t   cmd;
    entry_t fresh;
  } cell_ctrl_t;

  // true when a is served strictly before b
  function automatic logic better(entry_t a, entry_t b);
    logic r;
    r = (a.prio > b.prio) || ((a.prio == b.prio) && (a.value > b.value));
    return r;
  endfunction

endpackage

[design/apq_cell.sv]
module apq_cell (
  input  logic               clk,
  input  apq_pkg::cell_ctrl_t ctrl,
  input  logic               valid,
  input  logic               upper_take,
  input  apq_pkg::entry_t    upper_entry,
  input  apq_pkg::entry_t    lower_entry,
  output apq_pkg::entry_t    entry,
  output logic               take
);
  import apq_pkg::*;

  entry_t entry_next;

  // a new entry belongs here or above when it beats this cell or the cell is empty
  assign take = !valid || better(ctrl.fresh, entry);

  // choose own next content from neighbours or the new entry
  always_comb begin
    entry_next = entry;
    case (ctrl.cmd)
      CMD_INSERT: begin
        if (upper_take) begin
          entry_next = upper_entry;
        end else if (take) begin
          entry_next = ctrl.fresh;
        end
      end
      CMD_REMOVE: begin
        entry_next = lower_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[design/array_priority_queue_unit.sv]
// Bounded max-priority queue built as a sorted chain of cells.
// Requests arrive on the s_ channel: s_tuser selects insert (0) or remove (1),
// s_tdata carries the entry to insert. Every request gives exactly one result
// on the m_ channel: m_tuser is the status (done, full, empty), m_tdata holds
// the removed entry (zero unless a remove succeeded) and the entry count
// after the request.
// The chain is kept sorted best first: highest priority, then highest value,
// then earliest inserted. An insert drops into place, each cell
// comparing the new entry with its own and taking it or its upper neighbour;
// a remove takes the head cell and shifts the whole chain up by one.
// One request is taken every cycle while the receiver keeps up, the limit
// being the single compare in each cell.
// The result sits in an output register; a new request is taken while that
// register is empty or is being read, so a stalled receiver holds s_tready low
// only while a result is waiting.
// Reset clears the fill count and the result valid flag; stored entries
// are left as they are and count as empty.
module array_priority_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // item_value [31:0], item_priority [47:32]
  input  logic [0:0]  s_tuser,   // operation [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_value [31:0], out_priority [47:32],
                                 // entry_count [54:48], zero [55]
  output logic [1:0]  m_tuser    // status [1:0]
);
  import apq_pkg::*;

  logic [CountW-1:0]    count;
  logic [CountW-1:0]    count_next;
  logic                 accept;
  cell_ctrl_t           ctrl;
  entry_t               cell_entry [Capacity];
  logic                 cell_take  [Capacity];
  logic                 cell_valid [Capacity];
  logic [1:0]           res_status;
  logic [1:0]           res_status_next;
  entry_t               res_entry;
  entry_t               res_entry_next;
  logic [OutCountW-1:0] res_count;

  // request handshake
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // decode the request into a chain command and the result
  always_comb begin
    ctrl.fresh      = entry_t'(s_tdata);
    ctrl.cmd        = CMD_HOLD;
    count_next      = count;
    res_status_next = StatusDone;
    res_entry_next  = '0;
    if (accept) begin
      if (s_tuser[0] == OpInsert) begin
        if (count == CountW'(Capacity)) begin
          res_status_next = StatusFull;
        end else begin
          ctrl.cmd   = CMD_INSERT;
          count_next = count + CountW'(1);
        end
      end else begin
        if (count == '0) begin
          res_status_next = StatusEmpty;
        end else begin
          ctrl.cmd       = CMD_REMOVE;
          count_next     = count - CountW'(1);
          res_entry_next = cell_entry[0];
        end
      end
    end
  end

  // chain of cells, head holds the best entry
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    assign cell_valid[i] = CountW'(i) < count;
    if (i == 0) begin : g_head
      apq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .valid       (cell_valid[i]),
        .upper_take  (1'b0),
        .upper_entry ('0),
        .lower_entry (cell_entry[i+1]),
        .entry       (cell_entry[i]),
        .take        (cell_take[i])
      );
    end else if (i == Capacity - 1) begin : g_tail
      apq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .valid       (cell_valid[i]),
        .upper_take  (cell_take[i-1]),
        .upper_entry (cell_entry[i-1]),
        .lower_entry (cell_entry[i]),
        .entry       (cell_entry[i]),
        .take        (cell_take[i])
      );
    end else begin : g_mid
      apq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .valid       (cell_valid[i]),
        .upper_take  (cell_take[i-1]),
        .upper_entry (cell_entry[i-1]),
        .lower_entry (cell_entry[i+1]),
        .entry       (cell_entry[i]),
        .take        (cell_take[i])
      );
    end
  end

  // fill count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= res_status_next;
      res_entry  <= res_entry_next;
      res_count  <= OutCountW'(count_next);
    end
  end

  assign m_tuser = res_status;
  assign m_tdata = {1'b0, res_count, res_entry.prio, res_entry.value};

endmodule

[bench/array_priority_queue_checker.sv]
module array_priority_queue_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // item_value [31:0], item_priority [47:32]
  input  logic [0:0]  s_tuser,   // operation [0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // out_value [31:0], out_priority [47:32],
                                 // entry_count [54:48], zero [55]
  input  logic [1:0]  m_tuser,   // status [1:0]
  output int          mismatches,
  output int          outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import apq_pkg::*;

  // one expected result
  typedef struct {
    logic [1:0]           status;
    logic [31:0]          value;
    logic [15:0]          prio;
    logic [OutCountW-1:0] count;
  } outcome_t;

  // shadow of the queue, kept in insertion order
  entry_t      held [Capacity];
  int unsigned fill;
  outcome_t    awaited [$];
  int          errs;

  // work out the result of one request and update the shadow queue
  function automatic outcome_t serve_request(logic op, logic [31:0] v, logic [15:0] p);
    outcome_t           res;
    int unsigned        best;
    logic signed [15:0] pi;
    logic signed [15:0] pb;
    logic signed [31:0] vi;
    logic signed [31:0] vb;
    res.status = StatusDone;
    res.value  = '0;
    res.prio   = '0;
    if (op == OpInsert) begin
      if (fill >= Capacity) begin
        res.status = StatusFull;
      end else begin
        held[fill].value = v;
        held[fill].prio  = p;
        fill++;
      end
    end else if (fill == 0) begin
      res.status = StatusEmpty;
    end else begin
      // scan for the best entry; strict compare keeps the earliest on a full tie
      best = 0;
      for (int unsigned i = 1; i < fill; i++) begin
        pi = held[i].prio;
        pb = held[best].prio;
        vi = held[i].value;
        vb = held[best].value;
        if (pi > pb || (pi == pb && vi > vb)) best = i;
      end
      res.value = held[best].value;
      res.prio  = held[best].prio;
      // close the gap
      for (int unsigned i = best; i + 1 < fill; i++) held[i] = held[i + 1];
      fill--;
    end
    res.count = fill[OutCountW-1:0];
    return res;
  endfunction

  // track requests and compare each result with the oldest expectation
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      fill = 0;
      errs = 0;
      awaited.delete();
    end else begin
      if (s_tvalid && s_tready)
        awaited.push_back(serve_request(s_tuser[0], s_tdata[31:0], s_tdata[47:32]));
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          $error("result with no request pending");
          errs++;
        end else begin
          want = awaited.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tuser);
            errs++;
          end
          if (m_tdata[31:0] !== want.value) begin
            $error("out_value: expected %0d, actual %0d",
                   $signed(want.value), $signed(m_tdata[31:0]));
            errs++;
          end
          if (m_tdata[47:32] !== want.prio) begin
            $error("out_priority: expected %0d, actual %0d",
                   $signed(want.prio), $signed(m_tdata[47:32]));
            errs++;
          end
          if (m_tdata[54:48] !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, m_tdata[54:48]);
            errs++;
          end
        end
      end
    end
    mismatches  <= errs;
    outstanding <= awaited.size();
  end

endmodule

[bench/array_priority_queue_unit_test.sv]
module array_priority_queue_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  import apq_pkg::*;

  localparam int StallLimit = 2000;
  localparam int RandomItems = 650;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  int          mismatches;
  int          outstanding;

  int send_idle_pct = 25;
  int recv_idle_pct = 66;
  int stall_cycles = 0;
  int bias_plan [7] = '{85, 50, 15, 95, 10, 60, 90};

  always #4 clk = ~clk;

  array_priority_queue_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  array_priority_queue_checker apq_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // receiver back-pressure
  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // present one request and hold it until taken
  task automatic issue(input logic op, input logic [31:0] v, input logic [15:0] p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {p, v};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // values: full range, a narrow band around zero for ties, or the extremes
  function automatic logic [31:0] pick_value();
    int tmp;
    tmp = $urandom_range(0, 6);
    case ($urandom_range(0, 3))
      1: return 32'(tmp - 3);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_priority();
    int tmp;
    tmp = $urandom_range(0, 4);
    case ($urandom_range(0, 3))
      1: return 16'(tmp - 2);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic op;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty removal, extremes, ties on priority and on both fields
    issue(OpRemove, 32'h1234_5678, 16'h5a5a);
    issue(OpInsert, 32'h7fff_ffff, 16'h7fff);
    issue(OpInsert, 32'h8000_0000, 16'h8000);
    issue(OpInsert, 32'h8000_0000, 16'h7fff);
    issue(OpInsert, 32'h7fff_ffff, 16'h8000);
    issue(OpInsert, 32'd0, 16'd0);
    issue(OpInsert, 32'd5, 16'd0);
    issue(OpInsert, 32'd5, 16'd0);
    issue(OpInsert, 32'hffff_ffff, 16'd0);
    issue(OpInsert, 32'd7, 16'hffff);
    repeat (9) issue(OpRemove, $urandom, 16'($urandom));
    issue(OpRemove, 32'hffff_ffff, 16'hffff);
    issue(OpInsert, 32'd3, 16'd1);
    issue(OpRemove, 32'd0, 16'd0);

    // random: insert bias changes per segment so the queue swings between empty and full
    for (int n = 0; n < RandomItems; n++) begin
      if (n == 220) begin
        send_idle_pct = 66;
        recv_idle_pct = 25;
      end
      if (n == 440) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      op = ($urandom_range(0, 99) < bias_plan[(n / 100) % 7]) ? OpInsert : OpRemove;
      issue(op, pick_value(), pick_priority());
    end
    s_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
